// ----- src/scalar_kalman_filter_top_defines.svh -----
// ----------------------------------------------------------------------------
// scalar kalman filter assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef SCALAR_KALMAN_FILTER_TOP_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_TOP_DEFINES_SVH

`ifndef SYNTH
`define SKF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SKF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SKF_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SKF_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- src/skf_pkg.sv -----
// ----------------------------------------------------------------------------
// skf_pkg
// shared widths and constants of the scalar kalman filter
// ----------------------------------------------------------------------------
`default_nettype none

package skf_pkg;

  localparam int SampleWidth  = 16;
  localparam int GainFracBits = 24;
  localparam int EstFracBits  = 16;
  localparam int GainW        = GainFracBits + 1;
  localparam int MagW         = 33;
  localparam int ProdW        = MagW + GainW;
  localparam int CntW         = $clog2(GainW);
  localparam int CfgIdxW      = 1;
  localparam int CfgDataW     = 32;

  localparam logic [31:0]      CovReset = 32'd17280532;
  localparam logic [GainW-1:0] GainOne  = GainW'(1) << GainFracBits;

  localparam logic [CfgIdxW-1:0] CfgProcessNoise = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgMeasNoise    = CfgIdxW'(1);

endpackage

`default_nettype wire

// ----- src/skf_div.sv -----
// ----------------------------------------------------------------------------
// skf_div
// restoring bit-serial divider, gain = (pred << frac) / denom, one bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module skf_div import skf_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [31:0]      pred_i,
  input  wire logic [32:0]      denom_i,
  output logic                  done_o,
  output logic [GainW-1:0]      quot_o
);

  logic [32:0]      rem_q, rem_d;
  logic [GainW-1:0] bits_q, bits_d;
  logic [GainW-1:0] quot_q, quot_d;
  logic [32:0]      den_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [33:0]      trial;
  logic [33:0]      diff;
  logic             ge;

  always_comb begin
    trial = {rem_q, bits_q[GainW-1]};
    ge    = trial >= {1'b0, den_q};
    diff  = trial - {1'b0, den_q};
    rem_d  = rem_q;
    bits_d = bits_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = {1'b0, pred_i[31:1]};
      bits_d = {pred_i[0], {GainFracBits{1'b0}}};
      quot_d = '0;
      cnt_d  = CntW'(GainW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? diff[32:0] : trial[32:0];
      bits_d = {bits_q[GainW-2:0], 1'b0};
      quot_d = {quot_q[GainW-2:0], ge};
      cnt_d  = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    bits_q <= bits_d;
    quot_q <= quot_d;
    if (start_i) begin
      den_q <= denom_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ----- src/skf_mul.sv -----
// ----------------------------------------------------------------------------
// skf_mul
// shift-and-add serial multiplier, one multiplier bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module skf_mul import skf_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [MagW-1:0]  mcand_i,
  input  wire logic [GainW-1:0] mplier_i,
  output logic                  done_o,
  output logic [ProdW-1:0]      prod_o
);

  logic [MagW-1:0]  mcand_q;
  logic [MagW-1:0]  hi_q, hi_d;
  logic [GainW-1:0] lo_q, lo_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [MagW:0]    sum;

  always_comb begin
    sum    = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);
    hi_d   = hi_q;
    lo_d   = lo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      hi_d   = '0;
      lo_d   = mplier_i;
      cnt_d  = CntW'(GainW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      hi_d  = sum[MagW:1];
      lo_d  = {sum[0], lo_q[GainW-1:1]};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    lo_q <= lo_d;
    if (start_i) begin
      mcand_q <= mcand_i;
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule

`default_nettype wire

// ----- src/scalar_kalman_filter_top.sv -----
// sequence per input beat: setup, divide, handoff, multiply, update; the divide and handoff
// steps are skipped when the gain denominator is zero
// the bit-serial divider runs first, then the two multipliers
// the multipliers for estimate and covariance run side by side, one gain bit a cycle
// one item in flight; the next beat is taken once the result sits in the output register
// reset: estimate 0, covariance 1.03 in q8.24, both noise registers 0
// ----------------------------------------------------------------------------
// scalar_kalman_filter_top
// one-dimensional fixed point kalman filter with serial divide and multiply
// ----------------------------------------------------------------------------
`default_nettype none
`include "scalar_kalman_filter_top_defines.svh"

module scalar_kalman_filter_top import skf_pkg::*; (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [CfgIdxW-1:0]            cfg_idx_i,
  input  wire logic [CfgDataW-1:0]           cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [SampleWidth-1:0] measurement_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [31:0]                 estimate_out_o,
  output logic                               gain_undefined_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PREP = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e           st_q;
  logic [31:0]      pn_q;
  logic [31:0]      mn_q;
  logic [31:0]      est_q;
  logic [31:0]      cov_q;
  logic [31:0]      pred_q;
  logic [MagW-1:0]  mag_q;
  logic             neg_q;
  logic             undef_q;
  logic             out_valid_q;
  logic [31:0]      out_est_q;
  logic             out_undef_q;

  logic             in_beat;
  logic             out_load;
  logic [32:0]      pred_sum;
  logic [31:0]      pred;
  logic signed [47:0] tgt_wide;
  logic [31:0]      tgt;
  logic [32:0]      diff;
  logic [32:0]      denom;
  logic             denom_zero;
  logic             div_start;
  logic             div_done;
  logic [GainW-1:0] div_quot;
  logic             mul_start;
  logic [GainW-1:0] mul_gain;
  logic             mule_done;
  logic             mulp_done;
  logic [ProdW-1:0] prod_e;
  logic [ProdW-1:0] prod_p;
  logic [MagW-1:0]  corr;
  logic [33:0]      est_next;

  assign in_ready_o = (st_q == ST_IDLE);
  assign in_beat    = in_valid_i && in_ready_o;
  assign out_load   = (st_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    pred_sum = {1'b0, cov_q} + {1'b0, pn_q};
    pred     = pred_sum[32] ? 32'hFFFF_FFFF : pred_sum[31:0];
    tgt_wide = 48'(measurement_i) <<< EstFracBits;
    if (tgt_wide > 48'sh0000_7FFF_FFFF) begin
      tgt = 32'h7FFF_FFFF;
    end else if (tgt_wide < -48'sh0000_8000_0000) begin
      tgt = 32'h8000_0000;
    end else begin
      tgt = tgt_wide[31:0];
    end
    diff = {tgt[31], tgt} - {est_q[31], est_q};
  end

  assign denom      = {1'b0, pred_q} + {1'b0, mn_q};
  assign denom_zero = (denom == '0);
  assign div_start  = (st_q == ST_PREP) && !denom_zero;
  assign mul_start  = ((st_q == ST_PREP) && denom_zero) || ((st_q == ST_DIV) && div_done);
  assign mul_gain   = (st_q == ST_DIV) ? div_quot : '0;

  skf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .pred_i  (pred_q),
    .denom_i (denom),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  skf_mul u_mul_est (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (mag_q),
    .mplier_i (mul_gain),
    .done_o   (mule_done),
    .prod_o   (prod_e)
  );

  skf_mul u_mul_cov (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  ({1'b0, pred_q}),
    .mplier_i (GainOne - mul_gain),
    .done_o   (mulp_done),
    .prod_o   (prod_p)
  );

  assign corr     = prod_e[GainFracBits+MagW-1:GainFracBits];
  assign est_next = neg_q ? ({{2{est_q[31]}}, est_q} - {1'b0, corr})
                          : ({{2{est_q[31]}}, est_q} + {1'b0, corr});

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pn_q <= '0;
      mn_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgProcessNoise: pn_q <= cfg_data_i;
        CfgMeasNoise:    mn_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      est_q       <= '0;
      cov_q       <= CovReset;
      out_valid_q <= 1'b0;
      undef_q     <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (st_q)
        ST_IDLE: begin
          if (in_beat) begin
            st_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          undef_q <= denom_zero;
          st_q    <= denom_zero ? ST_MUL : ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            st_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mule_done) begin
            est_q <= est_next[31:0];
            cov_q <= prod_p[GainFracBits+31:GainFracBits];
            st_q  <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            st_q <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      pred_q <= pred;
      neg_q  <= diff[32];
      mag_q  <= diff[32] ? (~diff + 33'd1) : diff;
    end
    if (out_load) begin
      out_est_q   <= est_q;
      out_undef_q <= undef_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign estimate_out_o   = out_est_q;
  assign gain_undefined_o = out_undef_q;

  `SKF_ASSERT_IMP(a_mul_sync, clk_i, rst_ni, 1'b1, mule_done == mulp_done)
  `SKF_ASSERT_IMP(a_gain_max, clk_i, rst_ni, div_done, div_quot <= GainOne)
  `SKF_ASSERT_IMP(a_undef_nocorr, clk_i, rst_ni, mule_done && undef_q, corr == '0)
  `SKF_ASSERT_NXT(a_beat_prep, clk_i, rst_ni, in_beat, st_q == ST_PREP)

endmodule

`default_nettype wire
